// ===== hw/rtl/bgfla_pkg.sv =====
// ----------------------------------------------------------------------------
// bgfla_pkg
// Shared types and constants for the grown free-list slot allocator.
// ----------------------------------------------------------------------------
package bgfla_pkg;

  // Field widths fixed by the request and result formats
  localparam int unsigned OP_W    = 3;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned SPB_W   = 11;

  localparam logic [SPB_W-1:0]   SPB_RESET = 11'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;

  // Request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_FIRST = 3'd2,
    OP_NEXT  = 3'd3,
    OP_CHECK = 3'd4
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_GROW,
    ST_ALLOC_RD,
    ST_ALLOC_WAIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FINISH
  } state_e;

endpackage

// ===== hw/rtl/block_grown_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// block_grown_free_list_allocator
// Slot index allocator with a free list threaded through a link store that
// grows one block of slots at a time.
// ----------------------------------------------------------------------------
// One request is taken at a time; all work goes through the single port of
// the link store. Check, free and unknown ops go from dispatch straight to
// the result; alloc first links the new block one slot at a time when it
// has to grow, then reads and pops the head; first/next read and check one
// slot at a time until an allocated slot or the last grown slot. A finished
// result sits in an output register, so the next request is accepted while
// it waits to be taken. slots_per_block is written through cfg_we_i /
// cfg_wdata_i; the user must write it only while idle (block does not enforce).
module block_grown_free_list_allocator
  import bgfla_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SPB_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OP_W-1:0]    op_i,
  input  logic [IDX_W-1:0]   index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SLOT_W-1:0]  slot_o,
  output logic               is_null_o,
  output logic [COUNT_W-1:0] live_count_o,
  output logic [COUNT_W-1:0] grown_slots_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1) + 1;

  logic [SPB_W-1:0] spb_q;
  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [LW-1:0]    mem_wdata;
  logic [LW-1:0]    mem_rdata;

  // Hold the block size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q <= SPB_RESET;
    end else if (cfg_we_i) begin
      spb_q <= cfg_wdata_i;
    end
  end

  bgfla_ram #(
    .WIDTH (LW),
    .DEPTH (CAPACITY)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  bgfla_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .spb_i         (spb_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .index_i       (index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .slot_o        (slot_o),
    .is_null_o     (is_null_o),
    .live_count_o  (live_count_o),
    .grown_slots_o (grown_slots_o),
    .mem_we_o      (mem_we),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata)
  );

endmodule

// ===== hw/rtl/bgfla_ram.sv =====
// ----------------------------------------------------------------------------
// bgfla_ram
// Generic single-port RAM with one address, write enable and registered read.
// ----------------------------------------------------------------------------
module bgfla_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on enable, register the read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bgfla_ctrl.sv =====
// ----------------------------------------------------------------------------
// bgfla_ctrl
// Sequencer and shared pointer unit: walks the link store for growth, pops,
// pushes and scans, and holds the result register.
// ----------------------------------------------------------------------------
module bgfla_ctrl
  import bgfla_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [SPB_W-1:0]              spb_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [OP_W-1:0]               op_i,
  input  logic [IDX_W-1:0]              index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [SLOT_W-1:0]             slot_o,
  output logic                          is_null_o,
  output logic [COUNT_W-1:0]            live_count_o,
  output logic [COUNT_W-1:0]            grown_slots_o,
  output logic                          mem_we_o,
  output logic [$clog2(CAPACITY)-1:0]   mem_addr_o,
  output logic [$clog2(CAPACITY + 1):0] mem_wdata_o,
  input  logic [$clog2(CAPACITY + 1):0] mem_rdata_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned GW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = GW + 1;
  localparam int unsigned CW = ((GW > COUNT_W) ? GW : COUNT_W) + 1;

  state_e state_q, state_d;

  logic [OP_W-1:0]    op_q, op_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [LW-1:0]      head_q, head_d;
  logic [GW-1:0]      grown_q, grown_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [GW-1:0]      cnt_q, cnt_d;
  logic [GW-1:0]      end_q, end_d;
  logic [AW-1:0]      res_slot_q, res_slot_d;
  logic               res_null_q, res_null_d;

  logic               out_valid_q, out_valid_d;
  logic [SLOT_W-1:0]  out_slot_q, out_slot_d;
  logic               out_null_q, out_null_d;
  logic [COUNT_W-1:0] out_live_q, out_live_d;
  logic [COUNT_W-1:0] out_grown_q, out_grown_d;

  logic [CW-1:0] idx_w, idx_inc_w, grown_w, head_w, grow_sum_w, res_slot_w;
  logic [GW-1:0] cnt_inc;
  logic          idx_in_range, head_at_top, head_above, grow_ok;
  logic          scan_done, link_null, out_free, in_fire;

  // Shared pointer arithmetic and compares
  assign idx_w        = CW'(idx_q);
  assign idx_inc_w    = idx_w + 1'b1;
  assign grown_w      = CW'(grown_q);
  assign head_w       = CW'(head_q);
  assign grow_sum_w   = grown_w + CW'(spb_i);
  assign res_slot_w   = CW'(res_slot_q);
  assign cnt_inc      = cnt_q + 1'b1;
  assign idx_in_range = idx_w < grown_w;
  assign head_at_top  = head_w == grown_w;
  assign head_above   = head_w > grown_w;
  assign grow_ok      = (spb_i != '0) && (grow_sum_w <= CW'(CAPACITY));
  assign scan_done    = cnt_q >= grown_q;
  assign link_null    = mem_rdata_i == '1;
  assign out_free     = !out_valid_q || out_ready_i;
  assign in_ready_o   = state_q == ST_IDLE;
  assign in_fire      = in_valid_i && in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (op_q)
          OP_ALLOC: begin
            if (head_at_top) begin
              state_d = grow_ok ? ST_GROW : ST_FINISH;
            end else begin
              state_d = head_above ? ST_FINISH : ST_ALLOC_RD;
            end
          end
          OP_FIRST: state_d = ST_SCAN_RD;
          OP_NEXT:  state_d = idx_in_range ? ST_SCAN_RD : ST_FINISH;
          default:  state_d = ST_FINISH;
        endcase
      end
      ST_GROW: begin
        if (cnt_inc == end_q) begin
          state_d = ST_ALLOC_RD;
        end
      end
      ST_ALLOC_RD:   state_d = ST_ALLOC_WAIT;
      ST_ALLOC_WAIT: state_d = ST_FINISH;
      ST_SCAN_RD:    state_d = scan_done ? ST_FINISH : ST_SCAN_CHK;
      ST_SCAN_CHK:   state_d = link_null ? ST_FINISH : ST_SCAN_RD;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:       state_d = ST_IDLE;
    endcase
  end

  // Datapath and link store access
  always_comb begin
    op_d        = op_q;
    idx_d       = idx_q;
    head_d      = head_q;
    grown_d     = grown_q;
    count_d     = count_q;
    cnt_d       = cnt_q;
    end_d       = end_q;
    res_slot_d  = res_slot_q;
    res_null_d  = res_null_q;
    out_valid_d = out_valid_q;
    out_slot_d  = out_slot_q;
    out_null_d  = out_null_q;
    out_live_d  = out_live_q;
    out_grown_d = out_grown_q;
    mem_we_o    = 1'b0;
    mem_addr_o  = cnt_q[AW-1:0];
    mem_wdata_o = LW'(cnt_inc);

    // Drop a taken result
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d  = op_i;
          idx_d = index_i;
        end
      end
      ST_DISPATCH: begin
        res_null_d = 1'b1;
        res_slot_d = '0;
        case (op_q)
          OP_ALLOC: begin
            if (head_at_top && grow_ok) begin
              cnt_d = grown_q;
              end_d = grow_sum_w[GW-1:0];
            end
          end
          OP_FREE: begin
            // Push the slot onto the free list
            if (idx_in_range) begin
              mem_we_o    = 1'b1;
              mem_addr_o  = idx_w[AW-1:0];
              mem_wdata_o = head_q;
              head_d      = idx_w[LW-1:0];
              if (count_q != '0) begin
                count_d = count_q - 1'b1;
              end
            end
          end
          OP_FIRST: cnt_d = '0;
          OP_NEXT:  cnt_d = idx_inc_w[GW-1:0];
          OP_CHECK: begin
            if (idx_in_range) begin
              res_null_d = 1'b0;
              res_slot_d = idx_w[AW-1:0];
            end
          end
          default: ;
        endcase
      end
      ST_GROW: begin
        // Link each new slot to its successor
        mem_we_o = 1'b1;
        cnt_d    = cnt_inc;
        if (cnt_inc == end_q) begin
          grown_d = end_q;
        end
      end
      ST_ALLOC_RD: begin
        mem_addr_o = head_q[AW-1:0];
      end
      ST_ALLOC_WAIT: begin
        // Pop the head and mark it allocated
        mem_we_o    = 1'b1;
        mem_addr_o  = head_q[AW-1:0];
        mem_wdata_o = '1;
        head_d      = mem_rdata_i;
        res_null_d  = 1'b0;
        res_slot_d  = head_q[AW-1:0];
        if (count_q != COUNT_MAX) begin
          count_d = count_q + 1'b1;
        end
      end
      ST_SCAN_RD: ;
      ST_SCAN_CHK: begin
        if (link_null) begin
          res_null_d = 1'b0;
          res_slot_d = cnt_q[AW-1:0];
        end else begin
          cnt_d = cnt_inc;
        end
      end
      ST_FINISH: begin
        // Load the result register once it is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_slot_d  = res_slot_w[SLOT_W-1:0];
          out_null_d  = res_null_q;
          out_live_d  = count_q;
          out_grown_d = grown_w[COUNT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      grown_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      grown_q     <= grown_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    idx_q       <= idx_d;
    cnt_q       <= cnt_d;
    end_q       <= end_d;
    res_slot_q  <= res_slot_d;
    res_null_q  <= res_null_d;
    out_slot_q  <= out_slot_d;
    out_null_q  <= out_null_d;
    out_live_q  <= out_live_d;
    out_grown_q <= out_grown_d;
  end

  assign out_valid_o   = out_valid_q;
  assign slot_o        = out_slot_q;
  assign is_null_o     = out_null_q;
  assign live_count_o  = out_live_q;
  assign grown_slots_o = out_grown_q;

endmodule

// ===== tb/sv/alloc_checker.sv =====
// ----------------------------------------------------------------------------
// alloc_checker
// Watches the request, result and register ports of the slot allocator,
// predicts every result from a private copy of the free list and compares.
// ----------------------------------------------------------------------------
// Each accepted request is run through the predictor at once and its
// expected reply is queued; each accepted result is compared field by field
// with the oldest queued reply. fail_count_o holds mismatches plus replies
// still waiting, so it is only meaningful once the traffic has drained.
module alloc_checker
  import bgfla_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SPB_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [OP_W-1:0]    op_i,
  input  logic [IDX_W-1:0]   index_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic               is_null_i,
  input  logic [COUNT_W-1:0] live_count_i,
  input  logic [COUNT_W-1:0] grown_slots_i,
  output int                 fail_count_o
);

  // Links need one bit above the slot range for the allocated mark
  localparam int unsigned LINK_W = 12;
  localparam logic [LINK_W-1:0] LINK_ALLOCATED = '1;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               is_null;
    logic [COUNT_W-1:0] live_count;
    logic [COUNT_W-1:0] grown_slots;
  } alloc_reply_t;

  logic [LINK_W-1:0]  link_store [CAPACITY];
  logic [LINK_W-1:0]  list_head;
  logic [COUNT_W-1:0] grown;
  logic [COUNT_W-1:0] live;
  logic [SPB_W-1:0]   spb_shadow;
  alloc_reply_t       expected_replies [$];
  int                 mismatches;

  // Lowest allocated slot at or above start, or -1
  function automatic int find_allocated(int unsigned start);
    for (int unsigned i = start; i < grown; i++) begin
      if (link_store[i] == LINK_ALLOCATED) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Apply one request to the shadow state and build its reply
  function automatic alloc_reply_t compute_reply(logic [OP_W-1:0] op,
                                                 logic [IDX_W-1:0] idx);
    alloc_reply_t reply;
    int           found;
    int unsigned  base;
    int unsigned  span;
    found = -1;
    base  = grown;
    span  = spb_shadow;
    case (op)
      OP_ALLOC: begin
        // Grow by one block when the free list has run dry and it still fits
        if (list_head == LINK_W'(grown) && span != 0 && base + span <= CAPACITY) begin
          for (int unsigned i = base; i < base + span; i++) begin
            link_store[i] = LINK_W'(i + 1);
          end
          grown = COUNT_W'(base + span);
        end
        // Pop the head unless growth failed or the list is broken
        if (list_head < LINK_W'(grown)) begin
          found = list_head;
          list_head = link_store[found];
          link_store[found] = LINK_ALLOCATED;
          if (live != COUNT_MAX) begin
            live = live + 1'b1;
          end
        end
      end
      OP_FREE: begin
        // Push without any double-free check
        if (idx < grown) begin
          link_store[idx] = list_head;
          list_head = LINK_W'(idx);
          if (live != '0) begin
            live = live - 1'b1;
          end
        end
      end
      OP_FIRST: begin
        found = find_allocated(0);
      end
      OP_NEXT: begin
        if (idx < grown) begin
          found = find_allocated(idx + 1);
        end
      end
      OP_CHECK: begin
        if (idx < grown) begin
          found = idx;
        end
      end
      default: begin
      end
    endcase
    reply.is_null     = (found < 0);
    reply.slot        = (found < 0) ? '0 : SLOT_W'(found);
    reply.live_count  = live;
    reply.grown_slots = grown;
    return reply;
  endfunction

  // Track configuration, predict on each request, compare on each result
  always @(posedge clk_i or negedge rst_ni) begin : track
    alloc_reply_t want;
    logic         bad;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        link_store[i] = '0;
      end
      list_head  = '0;
      grown      = '0;
      live       = '0;
      spb_shadow = SPB_RESET;
      expected_replies.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) begin
        spb_shadow = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        expected_replies.push_back(compute_reply(op_i, index_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("alloc_checker: unexpected result slot %0d null %0b live %0d grown %0d",
                     slot_i, is_null_i, live_count_i, grown_slots_i);
          end
        end else begin
          want = expected_replies.pop_front();
          bad = (slot_i != want.slot) || (is_null_i != want.is_null) ||
                (live_count_i != want.live_count) || (grown_slots_i != want.grown_slots);
          if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("alloc_checker: mismatch expected slot %0d null %0b live %0d grown %0d",
                       want.slot, want.is_null, want.live_count, want.grown_slots);
              $display("alloc_checker:          actual   slot %0d null %0b live %0d grown %0d",
                       slot_i, is_null_i, live_count_i, grown_slots_i);
            end
          end
        end
      end
    end
    fail_count_o = mismatches + expected_replies.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the grown free-list slot allocator.
// ----------------------------------------------------------------------------
// A directed pass covers the empty allocator, reserved ops, zero and oversize
// block sizes and single-slot growth. Random phases then run mostly
// well-formed alloc/free traffic (frees of slots known to be held) over
// several block sizes, one of which fills the store exactly to capacity,
// and a closing sequence breaks the free list with a double free. The
// sender idles in bursts and the receiver stalls on its own pattern.
module tb;
  import bgfla_pkg::*;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [SPB_W-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [OP_W-1:0]    op_i;
  logic [IDX_W-1:0]   index_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [SLOT_W-1:0]  slot_o;
  logic               is_null_o;
  logic [COUNT_W-1:0] live_count_o;
  logic [COUNT_W-1:0] grown_slots_o;
  int                 check_failures;

  // Stimulus bookkeeping: ops in flight, slots known to be held
  logic [OP_W-1:0]    issued_ops [$];
  logic [IDX_W-1:0]   live_slots [$];
  int                 sent_count = 0;
  int                 recv_count = 0;
  logic [COUNT_W-1:0] grown_seen = '0;
  int                 burst_left = 0;
  int                 stall_left = 0;
  int                 stall_mode = 0;
  int                 quiet_cycles = 0;

  block_grown_free_list_allocator #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .index_i      (index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .slot_o       (slot_o),
    .is_null_o    (is_null_o),
    .live_count_o (live_count_o),
    .grown_slots_o(grown_slots_o)
  );

  alloc_checker #(
    .CAPACITY(CAPACITY)
  ) u_alloc_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .op_i         (op_i),
    .index_i      (index_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .slot_i       (slot_o),
    .is_null_i    (is_null_o),
    .live_count_i (live_count_o),
    .grown_slots_i(grown_slots_o),
    .fail_count_o (check_failures)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: switch at random between stall patterns
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(64, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 3) != 0);
      2:       out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (stall_left[1:0] == 2'd0);
    endcase
  end

  // Harvest results: count them and remember slots handed out
  always @(posedge clk_i) begin : harvest
    logic [OP_W-1:0] done_op;
    if (rst_ni && out_valid_o && out_ready_i) begin
      recv_count <= recv_count + 1;
      grown_seen <= grown_slots_o;
      if (issued_ops.size() > 0) begin
        done_op = issued_ops.pop_front();
        if (done_op == OP_ALLOC && !is_null_o) begin
          live_slots.push_back(slot_o);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request, idling first when a burst has run out
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    index_i    <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    issued_ops.push_back(op);
    sent_count++;
    burst_left--;
  endtask

  // Hold off new requests until every result is back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (recv_count != sent_count) @(posedge clk_i);
  endtask

  // Write the slots-per-block register while the allocator is idle
  task automatic write_spb(input logic [SPB_W-1:0] value);
    wait_for_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    burst_left  = 0;
  endtask

  // Random traffic, mostly alloc and free of held slots
  task automatic run_mixed(input int count, input int alloc_weight);
    int               pick;
    int               k;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    repeat (count) begin
      pick = $urandom_range(0, alloc_weight + 54);
      op   = OP_CHECK;
      idx  = IDX_W'($urandom_range(0, CAPACITY - 1));
      if (pick < alloc_weight) begin
        op = OP_ALLOC;
      end else if (pick < alloc_weight + 30) begin
        // Out-of-range frees only when nothing is in flight, so growth cannot race
        if (live_slots.size() > 0 && $urandom_range(0, 7) != 0) begin
          k   = $urandom_range(0, live_slots.size() - 1);
          op  = OP_FREE;
          idx = live_slots[k];
          live_slots.delete(k);
        end else if (sent_count == recv_count && grown_seen < CAPACITY) begin
          op  = OP_FREE;
          idx = IDX_W'($urandom_range(grown_seen, CAPACITY - 1));
        end
      end else if (pick < alloc_weight + 35) begin
        op = OP_FIRST;
      end else if (pick < alloc_weight + 42) begin
        op = OP_NEXT;
        if (live_slots.size() > 0 && $urandom_range(0, 1) == 0) begin
          idx = live_slots[$urandom_range(0, live_slots.size() - 1)];
        end
      end else if (pick >= alloc_weight + 52) begin
        op = OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
      end
      send_request(op, idx);
    end
  endtask

  initial begin : stimulus
    logic [IDX_W-1:0] victim;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    op_i        = OP_ALLOC;
    index_i     = '0;
    out_ready_i = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty allocator: scans, checks and frees all miss; reserved ops do nothing
    send_request(OP_FIRST, '0);
    send_request(OP_NEXT, '0);
    send_request(OP_CHECK, '0);
    send_request(OP_CHECK, '1);
    send_request(OP_FREE, '0);
    send_request(OP_FREE, '1);
    for (int op = OP_RESERVED_FIRST; op <= OP_RESERVED_LAST; op++) begin
      send_request(OP_W'(op), IDX_W'($urandom_range(0, CAPACITY - 1)));
    end

    // Zero block size and a block larger than the store cannot grow
    write_spb('0);
    send_request(OP_ALLOC, '0);
    write_spb('1);
    send_request(OP_ALLOC, '1);

    // Single-slot growth, scans over two slots, reuse of a freed slot
    write_spb(SPB_W'(1));
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_NEXT, IDX_W'(0));
    send_request(OP_NEXT, IDX_W'(1));
    send_request(OP_FIRST, '0);
    send_request(OP_FREE, IDX_W'(0));
    send_request(OP_ALLOC, '0);
    send_request(OP_CHECK, IDX_W'(1));
    send_request(OP_CHECK, IDX_W'(2));

    // Full-store block no longer fits once anything has grown
    write_spb(SPB_W'(CAPACITY));
    send_request(OP_ALLOC, '0);

    // Random phases over several block sizes
    write_spb(SPB_RESET);
    run_mixed(200, 50);
    write_spb(SPB_W'(5));
    run_mixed(200, 45);
    write_spb(SPB_W'(1));
    run_mixed(150, 45);
    write_spb(SPB_W'(37));
    run_mixed(150, 60);

    // Next growth fills the store exactly to capacity
    wait_for_results();
    write_spb(SPB_W'(CAPACITY - grown_seen));
    run_mixed(300, 60);
    write_spb(SPB_W'(2));
    run_mixed(150, 50);

    // Double free: the slot is handed out twice, then the list is broken
    wait_for_results();
    victim = (live_slots.size() > 0) ? live_slots[0] : '0;
    send_request(OP_FREE, victim);
    send_request(OP_FREE, victim);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, victim);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_CHECK, victim);

    // Drain, allow stray results to show, then judge
    wait_for_results();
    repeat (50) @(posedge clk_i);
    if (check_failures == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bgfla_pkg.sv
hw/rtl/bgfla_ram.sv
hw/rtl/bgfla_ctrl.sv
hw/rtl/block_grown_free_list_allocator.sv
tb/sv/alloc_checker.sv
tb/sv/tb.sv
